// ===== rtl/binary_frame_deframer_assert.svh =====
// Assertion macros used by the frame deframer output buffer (bfd_out_buf).
// Each expects signals named clk and arst_n in the module that uses it.
`ifndef BINARY_FRAME_DEFRAMER_ASSERT_SVH
`define BINARY_FRAME_DEFRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bfd_pkg.sv =====
package bfd_pkg;

	localparam int unsigned BUF_SIZE_DEF     = 64;
	localparam int unsigned FRAME_OVERHEAD   = 5;
	localparam int unsigned TIME_PAYLOAD_LEN = 7;
	localparam int unsigned DATA_W           = 80;
	localparam int unsigned CFG_IDX_W        = 2;

	localparam logic [7:0] START_RESET = 8'd2;
	localparam logic [7:0] END_RESET   = 8'd3;
	localparam logic [7:0] SYNC_RESET  = 8'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_BYTE = 2'd0,
		REG_END_BYTE   = 2'd1,
		REG_SYNC_CODE  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STATUS_GOOD     = 2'd0,
		STATUS_CHECKSUM = 2'd1,
		STATUS_END_BYTE = 2'd2
	} frame_status_t;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_CMD,
		ST_LEN,
		ST_PAYLOAD,
		ST_CHECK,
		ST_END
	} parse_state_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] time_sync_code;
	} bfd_cfg_t;

	// Declared from the highest bits down, so frame_status lands in bits 1:0.
	typedef struct packed {
		logic [7:0]    day_value;
		logic [7:0]    month_value;
		logic [15:0]   year_value;
		logic [7:0]    second_value;
		logic [7:0]    minute_value;
		logic [7:0]    hour_value;
		logic          time_valid;
		logic [5:0]    payload_len;
		logic [7:0]    command;
		frame_status_t frame_status;
	} bfd_result_t;

endpackage

// ===== rtl/bfd_parser.sv =====
module bfd_parser #(
	parameter int unsigned BUF_SIZE = bfd_pkg::BUF_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  bfd_pkg::bfd_cfg_t   cfg,
	output logic                res_valid,
	output bfd_pkg::bfd_result_t res
);

	localparam int unsigned MAX_LEN = BUF_SIZE - bfd_pkg::FRAME_OVERHEAD;
	localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
	localparam int unsigned HEAD_N  = bfd_pkg::TIME_PAYLOAD_LEN;

	bfd_pkg::parse_state_t state_q, state_d;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] cnt_q;
	logic [7:0]       xor_q;
	logic [7:0]       cmd_q;
	logic [7:0]       chk_q;
	logic [7:0]       head_q [HEAD_N];
	logic             len_bad;
	logic             last_payload;
	logic             time_ok;
	bfd_pkg::frame_status_t status;

	assign len_bad      = in_byte > 8'(MAX_LEN);
	assign last_payload = LEN_W'(cnt_q + 1'b1) == len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfd_pkg::ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		res_valid = 1'b0;
		if (in_valid) begin
			unique case (state_q)
				bfd_pkg::ST_HUNT: begin
					if (in_byte == cfg.start_byte) begin
						state_d = bfd_pkg::ST_CMD;
					end
				end
				bfd_pkg::ST_CMD: begin
					state_d = bfd_pkg::ST_LEN;
				end
				bfd_pkg::ST_LEN: begin
					if (len_bad) begin
						state_d = bfd_pkg::ST_HUNT;
					end else if (in_byte == 8'd0) begin
						state_d = bfd_pkg::ST_CHECK;
					end else begin
						state_d = bfd_pkg::ST_PAYLOAD;
					end
				end
				bfd_pkg::ST_PAYLOAD: begin
					if (last_payload) begin
						state_d = bfd_pkg::ST_CHECK;
					end
				end
				bfd_pkg::ST_CHECK: begin
					state_d = bfd_pkg::ST_END;
				end
				bfd_pkg::ST_END: begin
					state_d   = bfd_pkg::ST_HUNT;
					res_valid = 1'b1;
				end
				default: begin
					state_d = bfd_pkg::ST_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cnt_q <= '0;
			xor_q <= '0;
			cmd_q <= '0;
			chk_q <= '0;
		end else if (in_valid) begin
			case (state_q)
				bfd_pkg::ST_CMD: begin
					cmd_q <= in_byte;
					xor_q <= in_byte;
				end
				bfd_pkg::ST_LEN: begin
					len_q <= LEN_W'(in_byte);
					cnt_q <= '0;
					xor_q <= xor_q ^ in_byte;
				end
				bfd_pkg::ST_PAYLOAD: begin
					cnt_q <= LEN_W'(cnt_q + 1'b1);
					xor_q <= xor_q ^ in_byte;
				end
				bfd_pkg::ST_CHECK: begin
					chk_q <= in_byte;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < HEAD_N; k++) begin
			if (in_valid && state_q == bfd_pkg::ST_PAYLOAD && 8'(cnt_q) == 8'(k)) begin
				head_q[k] <= in_byte;
			end
		end
	end

	always_comb begin
		if (in_byte != cfg.end_byte) begin
			status = bfd_pkg::STATUS_END_BYTE;
		end else if (xor_q != chk_q) begin
			status = bfd_pkg::STATUS_CHECKSUM;
		end else begin
			status = bfd_pkg::STATUS_GOOD;
		end
		time_ok = status == bfd_pkg::STATUS_GOOD && cmd_q == cfg.time_sync_code &&
			8'(len_q) == 8'(HEAD_N);

		res              = '0;
		res.frame_status = status;
		res.command      = cmd_q;
		res.payload_len  = 6'(len_q);
		res.time_valid   = time_ok;
		if (time_ok) begin
			res.hour_value   = head_q[0];
			res.minute_value = head_q[1];
			res.second_value = head_q[2];
			res.year_value   = {head_q[3], head_q[4]};
			res.month_value  = head_q[5];
			res.day_value    = head_q[6];
		end
	end

endmodule

// ===== rtl/bfd_out_buf.sv =====
`include "binary_frame_deframer_assert.svh"

module bfd_out_buf (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  bfd_pkg::bfd_result_t          push_data,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bfd_pkg::DATA_W-1:0]    out_data
);

	localparam int unsigned DW = bfd_pkg::DATA_W;

	logic                 main_valid_q;
	logic                 skid_valid_q;
	bfd_pkg::bfd_result_t main_q;
	bfd_pkg::bfd_result_t skid_q;
	logic                 pop;

	assign pop       = main_valid_q && out_ready;
	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = DW'(main_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q) begin
			main_valid_q <= push;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || (pop && !skid_valid_q)) begin
			if (push) begin
				main_q <= push_data;
			end
		end else if (pop) begin
			main_q <= skid_q;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	`BFD_ASSERT_NOW(a_skid_needs_main, skid_valid_q, main_valid_q, "Skid entry without main entry")
	`BFD_ASSERT_NOW(a_no_push_when_full, push, !skid_valid_q, "Request pushed into full buffer")
	`BFD_ASSERT_NEXT(a_skid_moves_up, pop && skid_valid_q, main_valid_q && !skid_valid_q,
		"Skid entry lost on drain")

endmodule

// ===== rtl/binary_frame_deframer.sv =====
// Binary frame deframer.
// The input stream (s_tvalid, s_tready, s_tdata) carries one received byte per
// request. The block hunts for the start byte, then takes a command byte, a
// length byte, the payload, an XOR checksum and the end byte. A length above
// BUF_SIZE-5 drops the frame without a result.
// At the end byte one result request is pushed into the output buffer and
// goes out on m_tvalid, m_tready, m_tdata with the frame status, command,
// length and, for a good seven-byte time-sync frame, the decoded time and date.
// One byte is taken per cycle while s_tready is high; the parser steps once
// per accepted byte and the running XOR covers command, length and payload.
// A two-entry output buffer lets input continue while a result waits; input
// stalls only when both entries are full.
// The start byte, end byte and time-sync code are written through the cfg
// port and reset to 2, 3 and 1. Reset returns the parser to hunting and
// empties the output buffer.
module binary_frame_deframer #(
	parameter int unsigned BUF_SIZE = bfd_pkg::BUF_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // rx_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// frame_status, command, payload_len, time_valid, hour_value, minute_value,
	// second_value, year_value, month_value, day_value, zero fill
	output logic [bfd_pkg::DATA_W-1:0]       m_tdata,
	input  logic                             cfg_wr_en,
	input  logic [bfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                       cfg_data
);

	bfd_pkg::bfd_cfg_t    cfg_q;
	bfd_pkg::bfd_result_t res;
	logic                 accept;
	logic                 res_valid;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte     <= bfd_pkg::START_RESET;
			cfg_q.end_byte       <= bfd_pkg::END_RESET;
			cfg_q.time_sync_code <= bfd_pkg::SYNC_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bfd_pkg::REG_START_BYTE: cfg_q.start_byte     <= cfg_data;
				bfd_pkg::REG_END_BYTE:   cfg_q.end_byte       <= cfg_data;
				bfd_pkg::REG_SYNC_CODE:  cfg_q.time_sync_code <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bfd_parser #(
		.BUF_SIZE(BUF_SIZE)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_byte  (s_tdata),
		.cfg      (cfg_q),
		.res_valid(res_valid),
		.res      (res)
	);

	bfd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata)
	);

endmodule

// ===== tb/tb_binary_frame_deframer.sv =====
`timescale 1ns / 100ps

module tb_binary_frame_deframer;
	import bfd_pkg::*;

	localparam int unsigned MAX_LEN = BUF_SIZE_DEF - FRAME_OVERHEAD;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;   // rx_byte
	logic                  m_tvalid;
	logic                  m_tready;
	// frame_status, command, payload_len, time_valid, hour_value, minute_value,
	// second_value, year_value, month_value, day_value, zero fill
	logic [DATA_W-1:0]     m_tdata;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [7:0]            cfg_data;

	logic [7:0]  start_val;
	logic [7:0]  end_val;
	logic [7:0]  sync_val;
	int unsigned frame_pos;
	int unsigned frame_len;
	logic [7:0]  xor_acc;
	logic [7:0]  cmd_held;
	logic [7:0]  chk_held;
	logic [7:0]  time_bytes [TIME_PAYLOAD_LEN];

	bfd_result_t frames_due [$];
	logic [7:0]  payload_buf [MAX_LEN];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_len;
	int err_count;
	int bytes_used;
	int frames_checked;
	int frames_good;
	int frames_time;
	int frames_bad;
	int frames_dropped;
	int quiet_cycles;

	binary_frame_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want) begin
			report_mismatch($sformatf("%s is 0x%0h, 0x%0h was due", name, got, want));
		end
	endtask

	// Tracks the parser for one accepted byte and queues the frame result
	// when the byte closes a frame.
	task automatic track_rx_byte(input logic [7:0] b);
		bfd_result_t r;
		bit          tv;
		if (frame_pos != 0 || b == start_val) begin
			bytes_used++;
		end
		if (frame_pos == 0) begin
			if (b == start_val) begin
				frame_pos = 1;
				xor_acc = 8'h00;
			end
		end else if (frame_pos == 1) begin
			cmd_held = b;
			xor_acc = b;
			frame_pos = 2;
		end else if (frame_pos == 2) begin
			if (b > MAX_LEN) begin
				frame_pos = 0;
				frame_len = 0;
				frames_dropped++;
			end else begin
				frame_len = b;
				xor_acc ^= b;
				frame_pos = 3;
			end
		end else if (frame_pos < 3 + frame_len) begin
			if (frame_pos - 3 < TIME_PAYLOAD_LEN) begin
				time_bytes[frame_pos - 3] = b;
			end
			xor_acc ^= b;
			frame_pos++;
		end else if (frame_pos == 3 + frame_len) begin
			chk_held = b;
			frame_pos++;
		end else begin
			r = '0;
			if (b != end_val) begin
				r.frame_status = STATUS_END_BYTE;
			end else if (xor_acc != chk_held) begin
				r.frame_status = STATUS_CHECKSUM;
			end else begin
				r.frame_status = STATUS_GOOD;
			end
			r.command = cmd_held;
			r.payload_len = 6'(frame_len);
			tv = (r.frame_status == STATUS_GOOD) && (cmd_held == sync_val) &&
				(frame_len == TIME_PAYLOAD_LEN);
			r.time_valid = tv;
			if (tv) begin
				r.hour_value = time_bytes[0];
				r.minute_value = time_bytes[1];
				r.second_value = time_bytes[2];
				r.year_value = {time_bytes[3], time_bytes[4]};
				r.month_value = time_bytes[5];
				r.day_value = time_bytes[6];
				frames_time++;
			end
			if (r.frame_status == STATUS_GOOD) begin
				frames_good++;
			end else begin
				frames_bad++;
			end
			frames_due.push_back(r);
			frame_pos = 0;
			frame_len = 0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do begin
			@(posedge clk);
		end while (!s_tready);
		track_rx_byte(b);
	endtask

	task automatic release_sender();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Feeds filler bytes until the parser is back to hunting for a start byte.
	task automatic flush_parser();
		while (frame_pos != 0) begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic wait_results_done();
		while (frames_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic settle_block();
		flush_parser();
		release_sender();
		wait_results_done();
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_START_BYTE: start_val = value;
			REG_END_BYTE:   end_val = value;
			REG_SYNC_CODE:  sync_val = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_traffic(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	task automatic send_frame(input logic [7:0] cmd, input int len, input bit bad_chk,
			input bit bad_end);
		logic [7:0] sum;
		flush_parser();
		sum = cmd ^ 8'(len);
		send_byte(start_val);
		send_byte(cmd);
		send_byte(8'(len));
		for (int i = 0; i < len; i++) begin
			send_byte(payload_buf[i]);
			sum ^= payload_buf[i];
		end
		send_byte(bad_chk ? sum ^ 8'($urandom_range(1, 255)) : sum);
		send_byte(bad_end ? end_val ^ 8'($urandom_range(1, 255)) : end_val);
	endtask

	task automatic random_frame();
		logic [7:0] cmd;
		int         len;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 25) begin
			cmd = sync_val;
			len = TIME_PAYLOAD_LEN;
		end else begin
			case ($urandom_range(5))
				0: cmd = start_val;
				1: cmd = end_val;
				2: cmd = sync_val;
				default: cmd = 8'($urandom_range(0, 255));
			endcase
			pick = $urandom_range(19);
			if (pick == 0) begin
				len = MAX_LEN;
			end else if (pick < 3) begin
				len = $urandom_range(0, MAX_LEN);
			end else begin
				len = $urandom_range(0, 10);
			end
		end
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
				0: payload_buf[i] = start_val;
				1: payload_buf[i] = end_val;
				default: payload_buf[i] = 8'($urandom_range(0, 255));
			endcase
		end
		send_frame(cmd, len, $urandom_range(9) == 0, $urandom_range(9) == 0);
	endtask

	task automatic run_random_traffic(input int n_bytes);
		int stop_at;
		int pick;
		stop_at = bytes_used + n_bytes;
		while (bytes_used < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 14) begin
				send_byte(start_val);
				send_byte(8'($urandom_range(0, 255)));
				send_byte(8'($urandom_range(MAX_LEN + 1, 255)));
			end else if (pick < 20) begin
				send_byte(start_val);
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				random_frame();
			end
		end
	endtask

	task automatic test_directed();
		set_traffic(0, 0);
		payload_buf[0] = 8'hFF;
		payload_buf[1] = 8'h00;
		payload_buf[2] = 8'd59;
		payload_buf[3] = 8'h07;
		payload_buf[4] = 8'hE8;
		payload_buf[5] = 8'd12;
		payload_buf[6] = 8'd31;
		send_frame(sync_val, TIME_PAYLOAD_LEN, 1'b0, 1'b0);
		send_frame(8'hFF, 0, 1'b0, 1'b0);
		send_byte(start_val);
		send_byte(8'h55);
		send_byte(8'(MAX_LEN + 1));
		send_frame(8'h00, 0, 1'b1, 1'b1);
		settle_block();
	endtask

	task automatic test_idle_phases();
		set_traffic(0, 0);
		run_random_traffic(300);
		set_traffic(74, 0);
		run_random_traffic(300);
		set_traffic(0, 74);
		run_random_traffic(300);
		set_traffic(18, 18);
		run_random_traffic(300);
		settle_block();
	endtask

	task automatic test_config_settings();
		set_traffic(18, 18);
		write_reg(REG_START_BYTE, 8'h00);
		write_reg(REG_END_BYTE, 8'hFF);
		write_reg(REG_SYNC_CODE, 8'h00);
		run_random_traffic(75);
		settle_block();
		write_reg(REG_START_BYTE, 8'hFF);
		write_reg(REG_END_BYTE, 8'h00);
		write_reg(REG_SYNC_CODE, 8'hFF);
		run_random_traffic(75);
		settle_block();
		write_reg(REG_START_BYTE, 8'($urandom_range(0, 255)));
		write_reg(REG_END_BYTE, 8'($urandom_range(0, 255)));
		write_reg(REG_SYNC_CODE, 8'($urandom_range(0, 255)));
		write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
		run_random_traffic(75);
		settle_block();
		write_reg(REG_START_BYTE, START_RESET);
		write_reg(REG_END_BYTE, END_RESET);
		write_reg(REG_SYNC_CODE, SYNC_RESET);
		run_random_traffic(75);
		settle_block();
	endtask

	task automatic test_backpressure();
		set_traffic(0, 0);
		hold_len = 300;
		for (int i = 0; i < 20; i++) begin
			send_frame(8'($urandom_range(0, 255)), 0, 1'b0, 1'b0);
		end
		settle_block();
	endtask

	task automatic test_sender_pause();
		set_traffic(0, 74);
		run_random_traffic(40);
		release_sender();
		wait_results_done();
		run_random_traffic(40);
		settle_block();
	endtask

	always @(negedge clk) begin
		if (hold_len > 0) begin
			m_tready <= 1'b0;
			hold_len = hold_len - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		bfd_result_t got;
		bfd_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = bfd_result_t'(m_tdata[$bits(bfd_result_t)-1:0]);
			if (frames_due.size() == 0) begin
				report_mismatch($sformatf("result 0x%0h with no frame pending", m_tdata));
			end else begin
				want = frames_due.pop_front();
				frames_checked++;
				check_field("frame_status", got.frame_status, want.frame_status);
				check_field("command", got.command, want.command);
				check_field("payload_len", got.payload_len, want.payload_len);
				check_field("time_valid", got.time_valid, want.time_valid);
				check_field("hour_value", got.hour_value, want.hour_value);
				check_field("minute_value", got.minute_value, want.minute_value);
				check_field("second_value", got.second_value, want.second_value);
				check_field("year_value", got.year_value, want.year_value);
				check_field("month_value", got.month_value, want.month_value);
				check_field("day_value", got.day_value, want.day_value);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		m_tready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = 8'h00;
		start_val = START_RESET;
		end_val = END_RESET;
		sync_val = SYNC_RESET;
		frame_pos = 0;
		frame_len = 0;
		xor_acc = 8'h00;
		cmd_held = 8'h00;
		chk_held = 8'h00;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_len = 0;
		err_count = 0;
		bytes_used = 0;
		frames_checked = 0;
		frames_good = 0;
		frames_time = 0;
		frames_bad = 0;
		frames_dropped = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_idle_phases();
		test_config_settings();
		test_backpressure();
		test_sender_pause();

		repeat (10) @(posedge clk);
		$display("Fed %0d frame bytes across four traffic mixes and four register settings.",
			bytes_used);
		$display("Compared %0d frames: %0d good, %0d time sync, %0d bad; %0d dropped for length.",
			frames_checked, frames_good, frames_time, frames_bad, frames_dropped);
		if (err_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
